### sv/tick_driven_uart_tx_rx_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tick-driven UART checker
// ---------------------------------------------------------------------------
`ifndef TICK_DRIVEN_UART_TX_RX_MACROS_SVH
`define TICK_DRIVEN_UART_TX_RX_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define TDU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define TDU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tdu_pkg.sv
// ---------------------------------------------------------------------------
// tdu_pkg
// Shared constants and types for the tick-driven UART transmitter/receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdu_pkg;

    // Default number of data bits in a frame
    localparam int DATA_BITS_DEF = 8;
    // Width of the displayed receive byte
    localparam int RX_DATA_W     = 8;

    // Item kinds on the input channel
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_EDGE = 2'd1;
    localparam logic [1:0] MODE_LOAD = 2'd2;

    // Decoded actions of one accepted transaction
    typedef struct packed {
        logic tick_tx;   // bit tick while transmitting
        logic tick_rx;   // bit tick while receiving
        logic edge_rec;  // line edge while the timer runs: record level
        logic rx_start;  // falling edge while the timer is idle
        logic load;      // byte load while the transmitter is free
    } t_evt;

endpackage

### sv/tdu_tx.sv
// ---------------------------------------------------------------------------
// tdu_tx
// Transmit side: frames a byte as start, data (LSB first), stop and drives
// one frame bit onto the pin per bit tick.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdu_tx
    import tdu_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_evt                 i_evt,
    input  logic [7:0]           i_tx_byte,
    output logic                 o_sending,
    output logic                 o_pin,
    output logic                 o_frame_end
);

    localparam int FRAME_LEN = DATA_BITS + 2;
    localparam int IDX_W     = $clog2(FRAME_LEN);
    localparam int CNT_W     = $clog2(FRAME_LEN + 1);

    logic                 r_sending, n_sending;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic [FRAME_LEN-1:0] r_frame, n_frame;
    logic                 r_pin, n_pin;
    logic                 w_in_frame;

    assign w_in_frame  = (r_idx < CNT_W'(FRAME_LEN));
    assign o_frame_end = i_evt.tick_tx && !w_in_frame;

    // Load a new frame or advance the current one
    always_comb begin
        n_sending = r_sending;
        n_idx     = r_idx;
        n_frame   = r_frame;
        n_pin     = r_pin;
        if (i_evt.load) begin
            n_frame   = {1'b1, DATA_BITS'(i_tx_byte), 1'b0};
            n_idx     = '0;
            n_sending = 1'b1;
        end else if (i_evt.tick_tx) begin
            if (w_in_frame) begin
                n_pin = r_frame[r_idx[IDX_W-1:0]];
                n_idx = r_idx + CNT_W'(1);
            end else begin
                n_sending = 1'b0;
                n_idx     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending <= 1'b0;
            r_idx     <= '0;
            r_frame   <= {1'b1, {(FRAME_LEN-1){1'b0}}};
            r_pin     <= 1'b1;
        end else begin
            r_sending <= n_sending;
            r_idx     <= n_idx;
            r_frame   <= n_frame;
            r_pin     <= n_pin;
        end
    end

    assign o_sending = r_sending;
    assign o_pin     = r_pin;

endmodule

### sv/tdu_rx.sv
// ---------------------------------------------------------------------------
// tdu_rx
// Receive side: records the line level on edges and ORs the sampled level
// into the byte through a shifting bit mask, one position per bit tick.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdu_rx
    import tdu_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_evt                 i_evt,
    input  logic                 i_line_level,
    output logic [RX_DATA_W-1:0] o_shown,
    output logic                 o_done
);

    logic [DATA_BITS-1:0] r_mask, n_mask;
    logic [DATA_BITS-1:0] r_shift, n_shift;
    logic                 r_seen, n_seen;
    logic [RX_DATA_W-1:0] r_shown, n_shown;

    assign o_done = i_evt.tick_rx && (r_mask == '0);

    // Start, record level, sample a bit or finish the byte
    always_comb begin
        n_mask  = r_mask;
        n_shift = r_shift;
        n_seen  = r_seen;
        n_shown = r_shown;
        if (i_evt.rx_start) begin
            n_mask  = DATA_BITS'(1);
            n_shift = '0;
            n_seen  = 1'b0;
        end else if (i_evt.edge_rec) begin
            n_seen = i_line_level;
        end else if (i_evt.tick_rx) begin
            if (r_mask == '0) begin
                n_shown = RX_DATA_W'(r_shift);
            end else begin
                if (r_seen) begin
                    n_shift = r_shift | r_mask;
                end
                n_mask = r_mask << 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= DATA_BITS'(1);
            r_shift <= '0;
            r_seen  <= 1'b0;
            r_shown <= '0;
        end else begin
            r_mask  <= n_mask;
            r_shift <= n_shift;
            r_seen  <= n_seen;
            r_shown <= n_shown;
        end
    end

    assign o_shown = r_shown;

endmodule

### sv/tick_driven_uart_tx_rx.sv
// ---------------------------------------------------------------------------
// tick_driven_uart_tx_rx
// 8N1 UART with one bit timer shared by the transmitter and the receiver.
// ---------------------------------------------------------------------------
// Each input transaction is a bit tick, a receive-line edge or a byte load,
// and produces exactly one result, valid the cycle after it is accepted. The
// block takes one transaction per clock: the UART state registers are the
// result register, so a new transaction is accepted whenever no result is
// held or the held result is taken in the same cycle (o_in_ready follows
// i_out_ready while a result waits). Bit timing comes entirely from the tick
// source, including any half-bit alignment of receive sampling.
`timescale 1ns / 1ps

module tick_driven_uart_tx_rx
    import tdu_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_mode,
    input  logic                 i_line_level,
    input  logic [7:0]           i_tx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_tx_line,
    output logic [RX_DATA_W-1:0] o_rx_data,
    output logic                 o_rx_done,
    output logic                 o_tx_busy,
    output logic                 o_timer_running
);

    logic r_timer, n_timer;
    logic r_done, n_done;
    logic r_out_valid, n_out_valid;
    logic w_accept;
    logic w_sending;
    logic w_frame_end;
    logic w_rx_done;
    t_evt w_evt;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Decode the accepted transaction against the current timer owner
    always_comb begin
        w_evt          = '0;
        w_evt.tick_tx  = w_accept && (i_mode == MODE_TICK) && r_timer && w_sending;
        w_evt.tick_rx  = w_accept && (i_mode == MODE_TICK) && r_timer && !w_sending;
        w_evt.edge_rec = w_accept && (i_mode == MODE_EDGE) && r_timer;
        w_evt.rx_start = w_accept && (i_mode == MODE_EDGE) && !r_timer && !i_line_level;
        w_evt.load     = w_accept && (i_mode == MODE_LOAD) && !w_sending;
    end

    tdu_tx #(
        .DATA_BITS (DATA_BITS)
    ) u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (w_evt),
        .i_tx_byte   (i_tx_byte),
        .o_sending   (w_sending),
        .o_pin       (o_tx_line),
        .o_frame_end (w_frame_end)
    );

    tdu_rx #(
        .DATA_BITS (DATA_BITS)
    ) u_rx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (w_evt),
        .i_line_level (i_line_level),
        .o_shown      (o_rx_data),
        .o_done       (w_rx_done)
    );

    // Start the shared timer on a load or a start edge, drop it at frame or reception end
    always_comb begin
        n_timer = r_timer;
        if (w_evt.load || w_evt.rx_start) begin
            n_timer = 1'b1;
        end else if (w_frame_end || w_rx_done) begin
            n_timer = 1'b0;
        end
    end

    // Hold the result until it is taken
    always_comb begin
        n_done      = r_done;
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_done      = w_rx_done;
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer     <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_timer     <= n_timer;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_rx_done       = r_done;
    assign o_tx_busy       = w_sending;
    assign o_timer_running = r_timer;

endmodule

### sv/tdu_checker.sv
// ---------------------------------------------------------------------------
// tdu_checker
// Port-level assertions for the tick-driven UART, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tick_driven_uart_tx_rx_macros.svh"

module tdu_checker
    import tdu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  logic [1:0]           i_mode,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  logic                 o_tx_line,
    input  logic [RX_DATA_W-1:0] o_rx_data,
    input  logic                 o_rx_done,
    input  logic                 o_tx_busy,
    input  logic                 o_timer_running
);

    // Stalled result holds its payload
    `TDU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_rst_n && o_out_valid && !i_out_ready, o_out_valid && $stable(o_rx_data) && $stable(o_tx_line) && $stable(o_rx_done), "result changed while stalled")

    // A transmit frame always owns the running timer
    `TDU_ASSERT_NOW(a_busy_timer, i_clk, i_rst_n, o_tx_busy, o_timer_running, "transmitter busy with timer off")

    // A completed reception releases the timer
    `TDU_ASSERT_NOW(a_done_timer, i_clk, i_rst_n, o_out_valid && o_rx_done, !o_timer_running && !o_tx_busy, "reception done with timer still on")

    // A load taken while idle starts a frame
    `TDU_ASSERT_NEXT(a_load_start, i_clk, i_rst_n, i_rst_n && i_in_valid && o_in_ready && (i_mode == MODE_LOAD) && !o_tx_busy, o_tx_busy && o_timer_running, "load did not start a frame")

    // The shown byte moves only with a completed reception
    `TDU_ASSERT_NEXT(a_rx_hold, i_clk, i_rst_n, i_rst_n && i_in_valid && o_in_ready, o_rx_done || (o_rx_data == $past(o_rx_data)), "received byte changed without completion")

endmodule

bind tick_driven_uart_tx_rx tdu_checker u_tdu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_mode          (i_mode),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_tx_line       (o_tx_line),
    .o_rx_data       (o_rx_data),
    .o_rx_done       (o_rx_done),
    .o_tx_busy       (o_tx_busy),
    .o_timer_running (o_timer_running)
);

### bench/tick_driven_uart_tx_rx_checker.sv
// ---------------------------------------------------------------------------
// tick_driven_uart_tx_rx_checker
// Watches both channels of the tick-driven UART, predicts every result from
// its own copy of the transmit and receive state, and compares field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tick_driven_uart_tx_rx_checker
    import tdu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [1:0]           i_mode,
    input  logic                 i_line_level,
    input  logic [7:0]           i_tx_byte,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_tx_line,
    input  logic [RX_DATA_W-1:0] i_rx_data,
    input  logic                 i_rx_done,
    input  logic                 i_tx_busy,
    input  logic                 i_timer_running,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int FRAME_LEN   = DATA_BITS_DEF + 2;
    localparam int PRINT_LIMIT = 50;

    // Pin and status snapshot that one transaction leaves behind
    typedef struct packed {
        logic                 tx_line;
        logic [RX_DATA_W-1:0] rx_data;
        logic                 rx_done;
        logic                 tx_busy;
        logic                 timer_running;
    } t_uart_status;

    // Shadow UART state
    logic                     timer_on;
    logic                     tx_active;
    logic [3:0]               tx_bit_idx;
    logic [FRAME_LEN-1:0]     tx_frame;
    logic                     tx_pin;
    logic [DATA_BITS_DEF-1:0] rx_mask;
    logic [DATA_BITS_DEF-1:0] rx_shift;
    logic                     rx_level;
    logic [RX_DATA_W-1:0]     rx_shown;

    t_uart_status status_q[$];
    t_uart_status want;
    int           mismatch_count = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = status_q.size();

    // Print one line for a mismatch (up to a limit) and count it
    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, exp_val);
        end
        mismatch_count++;
    endtask

    // Advance the shadow state by one transaction and return the pin/status view
    function automatic t_uart_status predict_uart_step(input logic [1:0] mode,
                                                       input logic level,
                                                       input logic [7:0] data_byte);
        t_uart_status st;
        logic         done;
        done = 1'b0;
        if (mode == MODE_TICK) begin
            if (timer_on) begin
                if (tx_active) begin
                    // step the frame out one bit, or close it one tick after the stop bit
                    if (tx_bit_idx < FRAME_LEN) begin
                        tx_pin     = tx_frame[tx_bit_idx];
                        tx_bit_idx = tx_bit_idx + 4'd1;
                    end else begin
                        timer_on   = 1'b0;
                        tx_active  = 1'b0;
                        tx_bit_idx = '0;
                    end
                end else if (rx_mask == '0) begin
                    // mask has shifted out: show the byte
                    timer_on = 1'b0;
                    rx_shown = rx_shift[RX_DATA_W-1:0];
                    done     = 1'b1;
                end else begin
                    if (rx_level) begin
                        rx_shift = rx_shift | rx_mask;
                    end
                    rx_mask = rx_mask << 1;
                end
            end
        end else if (mode == MODE_EDGE) begin
            // record the level while the timer runs; a falling edge starts a reception
            if (timer_on) begin
                rx_level = level;
            end else if (!level) begin
                rx_mask  = DATA_BITS_DEF'(1);
                rx_shift = '0;
                rx_level = 1'b0;
                timer_on = 1'b1;
            end
        end else if (mode == MODE_LOAD) begin
            // frame the byte; a pending reception loses the timer
            if (!tx_active) begin
                tx_frame   = {1'b1, data_byte[DATA_BITS_DEF-1:0], 1'b0};
                tx_bit_idx = '0;
                tx_active  = 1'b1;
                timer_on   = 1'b1;
            end
        end
        st.tx_line       = tx_pin;
        st.rx_data       = rx_shown;
        st.rx_done       = done;
        st.tx_busy       = tx_active;
        st.timer_running = timer_on;
        return st;
    endfunction

    // Compare results first, then queue the prediction for a new transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timer_on   = 1'b0;
            tx_active  = 1'b0;
            tx_bit_idx = '0;
            tx_frame   = '0;
            tx_frame[FRAME_LEN-1] = 1'b1;
            tx_pin     = 1'b1;
            rx_mask    = DATA_BITS_DEF'(1);
            rx_shift   = '0;
            rx_level   = 1'b0;
            rx_shown   = '0;
            status_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (status_q.size() == 0) begin
                    report_mismatch("result with nothing pending", 1, 0);
                end else begin
                    want = status_q.pop_front();
                    if (i_tx_line !== want.tx_line)
                        report_mismatch("tx_line", int'(i_tx_line), int'(want.tx_line));
                    if (i_rx_data !== want.rx_data)
                        report_mismatch("rx_data", int'(i_rx_data), int'(want.rx_data));
                    if (i_rx_done !== want.rx_done)
                        report_mismatch("rx_done", int'(i_rx_done), int'(want.rx_done));
                    if (i_tx_busy !== want.tx_busy)
                        report_mismatch("tx_busy", int'(i_tx_busy), int'(want.tx_busy));
                    if (i_timer_running !== want.timer_running)
                        report_mismatch("timer_running", int'(i_timer_running),
                                        int'(want.timer_running));
                end
            end
            if (i_in_valid && i_in_ready) begin
                status_q.push_back(predict_uart_step(i_mode, i_line_level, i_tx_byte));
            end
        end
    end

endmodule

### bench/tick_driven_uart_tx_rx_test.sv
// ---------------------------------------------------------------------------
// tick_driven_uart_tx_rx_test
// Stimulus and verdict for the tick-driven UART: directed corner cases, then
// random receive and transmit frames mixed with broken frames and noise.
// ---------------------------------------------------------------------------
// Both channels idle at random in three phases (sender light / receiver heavy,
// the reverse, then none). The output side holds off for a long stretch once
// so the block backs up its input, and the sender drains between phases.
`timescale 1ns / 1ps

module tick_driven_uart_tx_rx_test;
    import tdu_pkg::*;

    localparam logic [1:0] MODE_NONE   = 2'd3;
    localparam int FRAME_TICKS         = DATA_BITS_DEF + 3;
    localparam int PHASE_ITEMS         = 400;
    localparam int LONG_HOLD_CYCLES    = 60;
    localparam int CYCLE_LIMIT         = 200000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_mode;
    logic                 i_line_level;
    logic [7:0]           i_tx_byte;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_tx_line;
    logic [RX_DATA_W-1:0] o_rx_data;
    logic                 o_rx_done;
    logic                 o_tx_busy;
    logic                 o_timer_running;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int cycle_count    = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;

    always #5 i_clk = ~i_clk;

    tick_driven_uart_tx_rx dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_line_level    (i_line_level),
        .i_tx_byte       (i_tx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_tx_line       (o_tx_line),
        .o_rx_data       (o_rx_data),
        .o_rx_done       (o_rx_done),
        .o_tx_busy       (o_tx_busy),
        .o_timer_running (o_timer_running)
    );

    tick_driven_uart_tx_rx_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_line_level    (i_line_level),
        .i_tx_byte       (i_tx_byte),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_tx_line       (o_tx_line),
        .i_rx_data       (o_rx_data),
        .i_rx_done       (o_rx_done),
        .i_tx_busy       (o_tx_busy),
        .i_timer_running (o_timer_running),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Drive the result-side ready: long hold on request, random stalls otherwise
    always @(negedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one transaction after a random gap and hold it until accepted
    task automatic offer(input logic [1:0] mode, input logic level, input logic [7:0] data_byte);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_line_level <= level;
        i_tx_byte    <= data_byte;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic tick();
        offer(MODE_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    // Enough ticks to close any frame in progress and free the timer
    task automatic settle();
        repeat (FRAME_TICKS) tick();
    endtask

    // Receive a byte: falling start edge, an edge on level changes, one tick per
    // bit and a final tick to show the byte; stop early after bits_kept bits
    task automatic receive_frame(input logic [7:0] bits, input int bits_kept);
        logic prev;
        prev = 1'b0;
        offer(MODE_EDGE, 1'b0, 8'($urandom_range(255)));
        for (int i = 0; i < 8; i++) begin
            if (i >= bits_kept) return;
            if (bits[i] != prev || $urandom_range(99) < 20) begin
                offer(MODE_EDGE, bits[i], 8'($urandom_range(255)));
            end
            prev = bits[i];
            tick();
        end
        tick();
    endtask

    // Send a byte: load, then ticks through the stop bit, with stray line edges
    task automatic send_frame(input logic [7:0] data_byte);
        offer(MODE_LOAD, 1'($urandom_range(1)), data_byte);
        repeat (FRAME_TICKS) begin
            if ($urandom_range(99) < 15) begin
                offer(MODE_EDGE, 1'($urandom_range(1)), 8'($urandom_range(255)));
            end
            tick();
        end
    endtask

    // Pause the sender until every expected result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Mostly well-formed frames, some cut short or taken over, some noise
    task automatic random_traffic(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                receive_frame(8'($urandom_range(255)), 8);
            end else if (pick < 70) begin
                send_frame(8'($urandom_range(255)));
            end else if (pick < 85) begin
                // cut a reception short, then let a load take over or flush
                receive_frame(8'($urandom_range(255)), int'($urandom_range(7)));
                if ($urandom_range(1)) send_frame(8'($urandom_range(255)));
                else settle();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    offer(2'($urandom_range(3)), 1'($urandom_range(1)),
                          8'($urandom_range(255)));
                end
                if ($urandom_range(1)) settle();
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_mode       = MODE_TICK;
        i_line_level = 1'b0;
        i_tx_byte    = '0;
        i_out_ready  = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // idle timer: tick, rising edge and the unused mode do nothing
        offer(MODE_TICK, 1'b1, 8'hFF);
        offer(MODE_EDGE, 1'b1, 8'h00);
        offer(MODE_NONE, 1'b1, 8'hFF);
        // start a reception, then let a load take the timer away from it
        offer(MODE_EDGE, 1'b0, 8'h00);
        offer(MODE_EDGE, 1'b1, 8'hFF);
        offer(MODE_TICK, 1'b0, 8'h00);
        offer(MODE_LOAD, 1'b0, 8'h00);
        // a second load while sending is dropped; an edge only records the level
        offer(MODE_LOAD, 1'b1, 8'hFF);
        offer(MODE_EDGE, 1'b0, 8'h00);
        settle();
        offer(MODE_TICK, 1'b0, 8'h00);
        drain();

        send_idle_pct  = 16;
        recv_stall_pct = 64;
        random_traffic(PHASE_ITEMS);
        drain();

        send_idle_pct  = 64;
        recv_stall_pct = 16;
        random_traffic(PHASE_ITEMS);
        drain();

        // no idling; hold the result side off while the sender keeps offering
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        random_traffic(PHASE_ITEMS);
        drain();

        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
